@@ src/fcpi_pkg.sv @@
`timescale 1ns / 1ps
package fcpi_pkg;
	localparam int AtanEntries = 24;
	localparam logic signed [17:0] HalfTurn = 18'sd23040;
	localparam logic signed [17:0] FullTurn = 18'sd46080;
	localparam logic signed [17:0] QuarterTurn = 18'sd11520;
	localparam logic signed [17:0] PitchLimit = 18'sd11392;
	localparam logic signed [15:0] AxisOne = 16'sd16384;
	localparam logic signed [33:0] CordicX0 = 34'sd652032874;

	localparam logic [0:0] RegInvertLook = 1'b0;
	localparam logic [0:0] RegMoveSpeed = 1'b1;

	function automatic logic signed [29:0] atan_entry(input logic [4:0] i);
		case (i)
			5'd0: atan_entry = 30'sd188743680;
			5'd1: atan_entry = 30'sd111421900;
			5'd2: atan_entry = 30'sd58872272;
			5'd3: atan_entry = 30'sd29884485;
			5'd4: atan_entry = 30'sd15000234;
			5'd5: atan_entry = 30'sd7507429;
			5'd6: atan_entry = 30'sd3754631;
			5'd7: atan_entry = 30'sd1877430;
			5'd8: atan_entry = 30'sd938729;
			5'd9: atan_entry = 30'sd469366;
			5'd10: atan_entry = 30'sd234683;
			5'd11: atan_entry = 30'sd117342;
			5'd12: atan_entry = 30'sd58671;
			5'd13: atan_entry = 30'sd29335;
			5'd14: atan_entry = 30'sd14668;
			5'd15: atan_entry = 30'sd7334;
			5'd16: atan_entry = 30'sd3667;
			5'd17: atan_entry = 30'sd1833;
			5'd18: atan_entry = 30'sd917;
			5'd19: atan_entry = 30'sd458;
			5'd20: atan_entry = 30'sd229;
			5'd21: atan_entry = 30'sd115;
			5'd22: atan_entry = 30'sd57;
			5'd23: atan_entry = 30'sd29;
			default: atan_entry = 30'sd0;
		endcase
	endfunction

	function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] v);
		if (v > AxisOne) clamp_axis = AxisOne;
		else if (v < -AxisOne) clamp_axis = -AxisOne;
		else clamp_axis = v;
	endfunction
endpackage

@@ src/fly_camera_pose_integrator.sv @@
`timescale 1ns / 1ps
// Channel   Signals                                   Direction
// in        in_valid/in_ready, frame_time..pitch_step request in
// out       out_valid/out_ready, heading..pos_z       request out
// cfg       cfg_we, cfg_index, cfg_data               register write
//
// Yaw and pitch go through the shared CORDIC one after the other, then one
// shared 33x33 multiplier forms the products in sequence, and the three
// axes move one after another. A new request is accepted only once the
// block is back in idle, after the final position write.
// Reset clears the angles and the position and sets move_speed to 1.0.
// The result sits in its own output register, so the block takes the next
// request while a result waits; only the final position write stalls until
// the output register is free.
module fly_camera_pose_integrator #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        frame_time,
	input  logic signed [15:0] forward_amount,
	input  logic signed [15:0] strafe_amount,
	input  logic signed [15:0] lift_amount,
	input  logic signed [15:0] yaw_step,
	input  logic signed [15:0] pitch_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] heading,
	output logic signed [14:0] elevation,
	output logic signed [47:0] pos_x,
	output logic signed [47:0] pos_y,
	output logic signed [47:0] pos_z,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import fcpi_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_YAW, S_YAW_W, S_PIT, S_PIT_W,
		S_FX, S_FZ, S_P0, S_P1, S_P2, S_P3, S_P4, S_K, S_MOVE, S_SAT, S_ACC
	} state_t;

	state_t             state_q;
	logic               invert_q;
	logic [15:0]        speed_q;
	logic signed [15:0] yaw_q;
	logic signed [14:0] pitch_q;
	logic signed [47:0] pos_q [3];
	logic [15:0]        dt_q;
	logic signed [15:0] fwd_q, str_q, lift_q;
	logic signed [15:0] sy_q, cy_q, sp_q, cp_q, fx_q, fz_q;
	logic signed [29:0] sum_q [3];
	logic [31:0]        k_q;
	logic [1:0]         axis_q;
	logic signed [48:0] dp_q;
	logic               mstep_q;
	logic signed [63:0] acc_q;
	logic signed [15:0] out_heading_q;
	logic signed [14:0] out_elevation_q;
	logic signed [47:0] out_pos_q [3];

	logic               cor_start, cor_done;
	logic signed [15:0] cor_angle, cor_sin, cor_cos;

	// Shared multiplier, 33 x 33 signed, registered after.
	logic signed [32:0] ma, mb;
	logic signed [65:0] mprod;
	logic signed [65:0] mprod_q;
	assign mprod = ma * mb;

	logic signed [17:0] yaw_sum, pit_sum, pstep_ext;
	logic signed [15:0] yaw_new;
	logic signed [14:0] pit_new;
	logic signed [29:0] fx_full, fz_full;
	logic signed [49:0] pos_sum;
	logic signed [47:0] pos_new;
	logic               out_load;

	always_comb begin
		yaw_sum = 18'(yaw_q) + 18'(yaw_step);
		if (yaw_sum > HalfTurn) yaw_sum = yaw_sum - FullTurn;
		else if (yaw_sum < -HalfTurn) yaw_sum = yaw_sum + FullTurn;
		yaw_new = yaw_sum[15:0];
		pstep_ext = invert_q ? -18'(pitch_step) : 18'(pitch_step);
		pit_sum = 18'(pitch_q) + pstep_ext;
		if (pit_sum > PitchLimit) pit_sum = PitchLimit;
		else if (pit_sum < -PitchLimit) pit_sum = -PitchLimit;
		pit_new = pit_sum[14:0];
		fx_full = 30'((mprod_q + 66'sd8192) >>> 14);
		fz_full = -30'((mprod_q + 66'sd8192) >>> 14);
		// Saturating position update for the axis in the accumulate step.
		pos_sum = 50'(pos_q[axis_q]) + 50'(dp_q);
		if (pos_sum > 50'sd140737488355327) pos_new = 48'sh7FFFFFFFFFFF;
		else if (pos_sum < -50'sd140737488355328) pos_new = 48'sh800000000000;
		else pos_new = pos_sum[47:0];
		out_load = (state_q == S_ACC) && (axis_q == 2'd2) && (!out_valid || out_ready);
		cor_angle = (state_q == S_YAW) ? yaw_q : 16'(pitch_q);
		cor_start = (state_q == S_YAW) || (state_q == S_PIT);
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_FX: begin ma = 33'(cp_q); mb = 33'(sy_q); end
			S_FZ: begin ma = 33'(cp_q); mb = 33'(cy_q); end
			S_P0: begin ma = 33'(str_q); mb = 33'(cy_q); end
			S_P1: begin ma = 33'(fwd_q); mb = 33'(fx_q); end
			S_P2: begin ma = 33'(fwd_q); mb = 33'(sp_q); end
			S_P3: begin ma = 33'(str_q); mb = 33'(sy_q); end
			S_P4: begin ma = 33'(fwd_q); mb = 33'(fz_q); end
			S_K:  begin ma = 33'({1'b0, speed_q}); mb = 33'({1'b0, dt_q}); end
			S_MOVE: begin
				// 30 x 32 product split into low and high 16 bits of k.
				ma = 33'(sum_q[axis_q]);
				mb = mstep_q ? 33'({1'b0, k_q[31:16]}) : 33'({1'b0, k_q[15:0]});
			end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	fcpi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .angle(cor_angle),
		.done(cor_done), .sin_q14(cor_sin), .cos_q14(cor_cos)
	);

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			invert_q <= 1'b0;
			speed_q <= 16'd256;
			yaw_q <= '0;
			pitch_q <= '0;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= '0;
			out_valid <= 1'b0;
			out_heading_q <= '0;
			out_elevation_q <= '0;
			out_pos_q[0] <= '0;
			out_pos_q[1] <= '0;
			out_pos_q[2] <= '0;
			axis_q <= '0;
			mstep_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					RegInvertLook: invert_q <= cfg_data[0];
					RegMoveSpeed: speed_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (out_load) begin
				out_heading_q <= yaw_q;
				out_elevation_q <= pitch_q;
				out_pos_q[0] <= pos_q[0];
				out_pos_q[1] <= pos_q[1];
				out_pos_q[2] <= pos_new;
			end
			mprod_q <= mprod;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					yaw_q <= yaw_new;
					pitch_q <= pit_new;
					dt_q <= frame_time;
					fwd_q <= clamp_axis(forward_amount);
					str_q <= clamp_axis(strafe_amount);
					lift_q <= clamp_axis(lift_amount);
					state_q <= S_YAW;
				end
				S_YAW: state_q <= S_YAW_W;
				S_YAW_W: if (cor_done) begin
					sy_q <= cor_sin;
					cy_q <= cor_cos;
					state_q <= S_PIT;
				end
				S_PIT: state_q <= S_PIT_W;
				S_PIT_W: if (cor_done) begin
					sp_q <= cor_sin;
					cp_q <= cor_cos;
					state_q <= S_FX;
				end
				S_FX: state_q <= S_FZ;
				S_FZ: begin
					fx_q <= fx_full[15:0];
					state_q <= S_P0;
				end
				S_P0: begin
					fz_q <= fz_full[15:0];
					state_q <= S_P1;
				end
				S_P1: begin
					sum_q[0] <= 30'(mprod_q);
					state_q <= S_P2;
				end
				S_P2: begin
					sum_q[0] <= sum_q[0] + 30'(mprod_q);
					state_q <= S_P3;
				end
				S_P3: begin
					sum_q[1] <= 30'(mprod_q) + (30'(lift_q) <<< 14);
					state_q <= S_P4;
				end
				S_P4: begin
					sum_q[2] <= 30'(mprod_q);
					state_q <= S_K;
				end
				S_K: begin
					sum_q[2] <= sum_q[2] + 30'(mprod_q);
					axis_q <= '0;
					mstep_q <= 1'b0;
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					if (!mstep_q) begin
						mstep_q <= 1'b1;
					end else begin
						mstep_q <= 1'b0;
						state_q <= S_SAT;
					end
					if (mstep_q) acc_q <= 64'(mprod_q);
					else acc_q <= acc_q;
				end
				S_SAT: begin
					// acc_q holds low partial; mprod_q holds high partial.
					dp_q <= 49'(((64'(mprod_q) <<< 16) + acc_q + 64'sd2147483648) >>> 32);
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (axis_q != 2'd2) begin
						pos_q[axis_q] <= pos_new;
						axis_q <= axis_q + 2'd1;
						state_q <= S_MOVE;
					end else if (out_load) begin
						pos_q[2] <= pos_new;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// The speed times frame time product is taken straight off the multiplier.
			if (state_q == S_K) k_q <= 32'(mprod);
		end
	end

	assign heading = out_heading_q;
	assign elevation = out_elevation_q;
	assign pos_x = out_pos_q[0];
	assign pos_y = out_pos_q[1];
	assign pos_z = out_pos_q[2];

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(heading) && $stable(pos_z))
		else $error("result changed while waiting");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_YAW)
		else $error("request not started");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_ACC)
		else $error("result without finish");
endmodule

@@ src/fcpi_cordic.sv @@
`timescale 1ns / 1ps
module fcpi_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [15:0]  angle,
	output logic                done,
	output logic signed [15:0]  sin_q14,
	output logic signed [15:0]  cos_q14
);
	import fcpi_pkg::*;

	localparam int Steps = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;

	typedef enum logic [1:0] {C_IDLE, C_RUN, C_OUT} cstate_t;

	cstate_t            state_q;
	logic [4:0]         step_q;
	logic signed [33:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic               flip_q;
	logic signed [17:0] a_ext, a_adj;
	logic               flip_d;
	logic signed [33:0] xs, ys, xf, yf, xr, yr;

	always_comb begin
		a_ext = 18'(angle);
		flip_d = 1'b0;
		a_adj = a_ext;
		if (a_ext > QuarterTurn) begin
			a_adj = a_ext - HalfTurn;
			flip_d = 1'b1;
		end else if (a_ext < -QuarterTurn) begin
			a_adj = a_ext + HalfTurn;
			flip_d = 1'b1;
		end
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		xf = flip_q ? -x_q : x_q;
		yf = flip_q ? -y_q : y_q;
		xr = (xf + 34'sd32768) >>> 16;
		yr = (yf + 34'sd32768) >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						x_q <= CordicX0;
						y_q <= '0;
						z_q <= 34'(a_adj) <<< 15;
						flip_q <= flip_d;
						step_q <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					if (!z_q[33]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - 34'(atan_entry(step_q));
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + 34'(atan_entry(step_q));
					end
					if (step_q == 5'(Steps - 1)) state_q <= C_OUT;
					step_q <= step_q + 5'd1;
				end
				C_OUT: begin
					if (xr > 34'sd16384) cos_q14 <= AxisOne;
					else if (xr < -34'sd16384) cos_q14 <= -AxisOne;
					else cos_q14 <= xr[15:0];
					if (yr > 34'sd16384) sin_q14 <= AxisOne;
					else if (yr < -34'sd16384) sin_q14 <= -AxisOne;
					else sin_q14 <= yr[15:0];
					done <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(state_q) == C_OUT)
		else $error("cordic done without finish");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_RUN) |-> step_q < 5'(Steps))
		else $error("cordic step overrun");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> state_q == C_IDLE)
		else $error("cordic done while busy");
endmodule
